// File: hw/rtl/npcm_pkg.sv
// Shared types and constants for the nearest palette color match core.
`timescale 1ns / 1ps
`default_nettype none

package npcm_pkg;

  // Palette geometry.
  localparam int PALETTE_SIZE = 16;
  localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int SLOT_W = 4;
  localparam int SLOT_CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int COLOR_W = 8;
  localparam int ENTRY_W = 3 * COLOR_W;

  // Distance arithmetic: the squares of weights 30, 59 and 11 (900, 3481, 121), applied to squared differences.
  localparam int SQ_W = 2 * COLOR_W;
  localparam int DIST_W = 29;
  localparam logic [DIST_W-1:0] WSQ_R = DIST_W'(900);
  localparam logic [DIST_W-1:0] WSQ_G = DIST_W'(3481);
  localparam logic [DIST_W-1:0] WSQ_B = DIST_W'(121);
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Item kinds carried in tuser.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Item as it moves from cell to cell, with the running best match.
  typedef struct packed {
    logic              valid;
    logic              opcode;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [SLOT_W-1:0] entry_index;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
  } chain_t;

endpackage

`default_nettype wire

// File: hw/rtl/npcm_cell.sv
// One palette cell: holds one entry, scores passing pixels against it in three stages.
`timescale 1ns / 1ps
`default_nettype none

module npcm_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire [npcm_pkg::IDX_W-1:0]    cell_id,
  input  npcm_pkg::chain_t             chain_in,
  output npcm_pkg::chain_t             chain_out
);
  import npcm_pkg::*;

  logic [ENTRY_W-1:0] entry_r, entry_nxt;
  chain_t             s1_r, s2_r, s3_r;
  logic [SQ_W-1:0]    sq_r_r, sq_g_r, sq_b_r;
  logic [SQ_W-1:0]    sq_r_nxt, sq_g_nxt, sq_b_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  chain_t             s3_nxt;
  logic [COLOR_W-1:0] d_r, d_g, d_b;
  logic               hit;

  // A palette write whose slot names this cell.
  assign hit = chain_in.valid && (chain_in.opcode == OP_WRITE) &&
               (SLOT_CMP_W'(chain_in.entry_index) == SLOT_CMP_W'(cell_id));

  always_comb begin
    entry_nxt = entry_r;
    if (hit) begin
      entry_nxt = {chain_in.red, chain_in.green, chain_in.blue};
    end
  end

  // Stage 1: absolute differences against the stored entry, then squares.
  always_comb begin
    d_r = (chain_in.red >= entry_r[23:16]) ? chain_in.red - entry_r[23:16]
                                           : entry_r[23:16] - chain_in.red;
    d_g = (chain_in.green >= entry_r[15:8]) ? chain_in.green - entry_r[15:8]
                                            : entry_r[15:8] - chain_in.green;
    d_b = (chain_in.blue >= entry_r[7:0]) ? chain_in.blue - entry_r[7:0]
                                          : entry_r[7:0] - chain_in.blue;
    sq_r_nxt = SQ_W'(d_r) * SQ_W'(d_r);
    sq_g_nxt = SQ_W'(d_g) * SQ_W'(d_g);
    sq_b_nxt = SQ_W'(d_b) * SQ_W'(d_b);
  end

  // Stage 2: constant weights and the sum.
  assign dist_nxt = DIST_W'(sq_r_r) * WSQ_R + DIST_W'(sq_g_r) * WSQ_G +
                    DIST_W'(sq_b_r) * WSQ_B;

  // Stage 3: a strictly smaller distance takes over, so ties keep the lower index.
  always_comb begin
    s3_nxt = s2_r;
    if (dist_r < s2_r.best_dist) begin
      s3_nxt.best_dist = dist_r;
      s3_nxt.best_idx  = cell_id;
    end
  end

  // Stage registers and the palette entry; reset clears the entry and the valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r    <= '0;
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else if (en) begin
      entry_r <= entry_nxt;
      s1_r    <= chain_in;
      sq_r_r  <= sq_r_nxt;
      sq_g_r  <= sq_g_nxt;
      sq_b_r  <= sq_b_nxt;
      s2_r    <= s1_r;
      dist_r  <= dist_nxt;
      s3_r    <= s3_nxt;
    end
  end

  assign chain_out = s3_r;

  // A matching write is stored on the edge that moves it into the cell.
  a_write_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (en && hit) |=> (entry_r == $past({chain_in.red, chain_in.green, chain_in.blue})))
    else $error("palette write not stored in its cell");

  // The running best distance never grows across the compare stage.
  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s2_r.valid) |=> (s3_r.best_dist <= $past(s2_r.best_dist)))
    else $error("best distance increased in a cell");

  // The winning index never points past this cell.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_r.valid && (s3_r.opcode == OP_PIXEL)) |-> (s3_r.best_idx <= cell_id))
    else $error("best index beyond current cell");

endmodule

`default_nettype wire

// File: hw/rtl/nearest_palette_color_match_core.sv
// Top level of the nearest palette color match core: a row of palette cells.
//
// Items arrive on the in_ stream. in_tuser selects the kind: 0 is a pixel,
// 1 writes a palette entry. A write stores {red, green, blue} into slot
// entry_index and gives no result; slots beyond the palette are ignored.
// Each pixel gives one transfer on the out_ stream carrying the index of
// the palette entry with the smallest weighted squared distance, the lowest
// index on ties.
// Every item walks through one cell per palette entry, three register stages
// per cell, then an output register. One item is accepted per cycle unless
// the receiver stalls, and writes and pixels keep their order through the row,
// so a pixel always sees exactly the writes that came before it.
// Reset clears all palette entries to black and empties the row.
// When the receiver stalls with a result waiting, the whole row holds and
// in_tready drops in the same cycle; it returns as soon as the result moves.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_match_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [31:0] in_tdata,   // red [7:0], green [15:8], blue [23:16], entry_index [27:24]
  input  wire        in_tuser,   // opcode [0]
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata   // color_index [3:0]
);
  import npcm_pkg::*;

  chain_t           link [PALETTE_SIZE+1];
  logic             en;
  logic             out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_idx_r;

  // The row advances whenever the output register is free or being drained.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Head of the row: unpack the transfer and seed the search.
  assign link[0] = '{valid:       in_tvalid,
                     opcode:      in_tuser,
                     red:         in_tdata[7:0],
                     green:       in_tdata[15:8],
                     blue:        in_tdata[23:16],
                     entry_index: in_tdata[27:24],
                     best_dist:   DIST_MAX,
                     best_idx:    '0};

  // One cell per palette entry.
  for (genvar k = 0; k < PALETTE_SIZE; k++) begin : g_cell
    npcm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .cell_id   (IDX_W'(k)),
      .chain_in  (link[k]),
      .chain_out (link[k+1])
    );
  end

  // Only pixels leave the row as results.
  assign out_valid_nxt = link[PALETTE_SIZE].valid &&
                         (link[PALETTE_SIZE].opcode == OP_PIXEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_idx_r <= SLOT_W'(link[PALETTE_SIZE].best_idx);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_idx_r};

  // A pixel leaving the last cell always becomes a result.
  a_pixel_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en && out_valid_nxt) |=> out_valid_r)
    else $error("pixel leaving the row produced no result");

  // A palette write leaving the row never becomes a result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (en && link[PALETTE_SIZE].valid && (link[PALETTE_SIZE].opcode == OP_WRITE))
      |=> !out_valid_r)
    else $error("palette write produced a result");

  // The row is frozen while a result waits.
  a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(link[PALETTE_SIZE]))
    else $error("row moved during output stall");

endmodule

`default_nettype wire

// File: tb/nearest_palette_color_match_core_tb.sv
// Self-checking testbench for the nearest palette color match core.
`timescale 1ns / 1ps

module nearest_palette_color_match_core_tb;

  localparam int NUM_RANDOM  = 1030;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 3 * npcm_pkg::PALETTE_SIZE + 12;
  localparam int DIR_N       = 22;

  // One row of the directed table; fixed_chk marks rows whose index is typed in.
  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] slot;
    logic       fixed_chk;
    logic [3:0] fixed_idx;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // red [7:0], green [15:8], blue [23:16], entry_index [27:24]
  logic        in_tuser = 1'b0; // opcode [0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // color_index [3:0]

  // Predictor state: a copy of the palette and the indexes still to arrive.
  logic [23:0] palette_model [npcm_pkg::PALETTE_SIZE] = '{default: '0};
  logic [3:0]  color_expect_q [$];

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned write_count = 0;
  int unsigned pixel_count = 0;
  int unsigned result_count = 0;
  int unsigned tie_pixels = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;

  localparam logic OP_PIX = npcm_pkg::OP_PIXEL;
  localparam logic OP_WR  = npcm_pkg::OP_WRITE;

  // Directed part: reset contents, extremes, ties and unwritten black slots.
  dir_row_t dir_rows [DIR_N] = '{
    '{OP_PIX, 8'd0,   8'd0,   8'd0,   4'd0,  1'b1, 4'd0},
    '{OP_PIX, 8'd255, 8'd255, 8'd255, 4'd15, 1'b1, 4'd0},
    '{OP_PIX, 8'd0,   8'd255, 8'd0,   4'd7,  1'b1, 4'd0},
    '{OP_WR,  8'd255, 8'd255, 8'd255, 4'd15, 1'b0, 4'd0},
    '{OP_PIX, 8'd255, 8'd255, 8'd255, 4'd0,  1'b1, 4'd15},
    '{OP_PIX, 8'd0,   8'd0,   8'd0,   4'd0,  1'b1, 4'd0},
    '{OP_WR,  8'd255, 8'd255, 8'd255, 4'd3,  1'b0, 4'd0},
    '{OP_PIX, 8'd255, 8'd255, 8'd255, 4'd9,  1'b1, 4'd3},
    '{OP_WR,  8'd255, 8'd0,   8'd0,   4'd0,  1'b0, 4'd0},
    '{OP_PIX, 8'd0,   8'd0,   8'd0,   4'd0,  1'b1, 4'd1},
    '{OP_PIX, 8'd255, 8'd0,   8'd0,   4'd0,  1'b1, 4'd0},
    '{OP_WR,  8'd0,   8'd255, 8'd0,   4'd1,  1'b0, 4'd0},
    '{OP_WR,  8'd0,   8'd0,   8'd255, 4'd2,  1'b0, 4'd0},
    '{OP_PIX, 8'd0,   8'd0,   8'd0,   4'd15, 1'b1, 4'd4},
    '{OP_PIX, 8'd0,   8'd0,   8'd255, 4'd0,  1'b1, 4'd2},
    '{OP_WR,  8'd0,   8'd255, 8'd255, 4'd4,  1'b0, 4'd0},
    '{OP_WR,  8'd2,   8'd0,   8'd0,   4'd5,  1'b0, 4'd0},
    '{OP_PIX, 8'd1,   8'd0,   8'd0,   4'd0,  1'b0, 4'd0},
    '{OP_PIX, 8'd128, 8'd64,  8'd200, 4'd0,  1'b0, 4'd0},
    '{OP_PIX, 8'd10,  8'd250, 8'd5,   4'd0,  1'b0, 4'd0},
    '{OP_PIX, 8'd200, 8'd200, 8'd0,   4'd0,  1'b0, 4'd0},
    '{OP_PIX, 8'd0,   8'd128, 8'd128, 4'd0,  1'b0, 4'd0}
  };

  nearest_palette_color_match_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Index of the palette entry with the smallest weighted squared distance.
  // A later entry wins only when strictly closer, so ties keep the lowest index.
  function automatic logic [3:0] nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    logic [31:0] best_d;
    logic [31:0] d;
    logic [31:0] dr;
    logic [31:0] dg;
    logic [31:0] db;
    logic [7:0]  er;
    logic [7:0]  eg;
    logic [7:0]  eb;
    int          best;
    best = 0;
    best_d = '0;
    for (int k = 0; k < npcm_pkg::PALETTE_SIZE; k++) begin
      er = palette_model[k][23:16];
      eg = palette_model[k][15:8];
      eb = palette_model[k][7:0];
      dr = 32'((r >= er) ? (r - er) : (er - r)) * 32'd30;
      dg = 32'((g >= eg) ? (g - eg) : (eg - g)) * 32'd59;
      db = 32'((b >= eb) ? (b - eb) : (eb - b)) * 32'd11;
      d = dr * dr + dg * dg + db * db;
      if (k == 0 || d < best_d) begin
        best_d = d;
        best = k;
      end
    end
    return best[3:0];
  endfunction

  // Counts palette entries equal to the pixel color (distance zero), to see that exact ties occur.
  function automatic bit exact_hit_tie(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    int hits;
    hits = 0;
    for (int k = 0; k < npcm_pkg::PALETTE_SIZE; k++) begin
      if (palette_model[k] == {r, g, b}) hits++;
    end
    return hits > 1;
  endfunction

  // A color component moved a few steps, kept inside 0..255.
  function automatic logic [7:0] jitter(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 12)) - 6;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] extreme_comp();
    return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
  endfunction

  function automatic int send_gap();
    return send_burst ? 0 : int'($urandom_range(0, 15));
  endfunction

  // Drives one item and waits for its transfer; then updates the predictor.
  task automatic send_item(input logic op, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [3:0] slot,
                           input logic fixed_chk, input logic [3:0] fixed_idx,
                           input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0000, slot, b, g, r};
    do @(posedge clk); while (!in_tready);
    if (op == OP_WR) begin
      write_count++;
      if (int'(slot) < npcm_pkg::PALETTE_SIZE) palette_model[slot] = {r, g, b};
    end else begin
      pixel_count++;
      if (exact_hit_tie(r, g, b)) tie_pixels++;
      color_expect_q.push_back(fixed_chk ? fixed_idx : nearest_entry(r, g, b));
    end
  endtask

  // Receiver: stall a drawn number of cycles, then accept one result.
  initial begin
    int stall;
    int n;
    n = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (n % 80 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      n++;
      stall = recv_burst ? 0 : int'($urandom_range(0, 15));
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare each result transfer with the oldest expected index.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (color_expect_q.size() == 0) begin
        error_count++;
        $display("%0t: result with no pixel pending: expected none, actual color_index %0d",
                 $time, out_tdata[3:0]);
      end else begin
        logic [3:0] want;
        want = color_expect_q.pop_front();
        if (out_tdata[3:0] !== want) begin
          error_count++;
          $display("%0t: color_index mismatch: expected %0d, actual %0d",
                   $time, want, out_tdata[3:0]);
        end
      end
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, color_expect_q.size());
      $display("nearest_palette_color_match_core_tb: errors");
      $finish;
    end
  end

  // Main stimulus.
  initial begin
    logic       op;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [3:0] slot;
    logic [23:0] ref_color;
    int unsigned pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < DIR_N; i++) begin
      send_item(dir_rows[i].op, dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                dir_rows[i].slot, dir_rows[i].fixed_chk, dir_rows[i].fixed_idx, send_gap());
    end

    // Random part: palette rewrites mixed with pixels that mostly sit near entries.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 100 == 0) send_burst = ($urandom_range(0, 3) == 0);
      op = ($urandom_range(0, 3) == 0) ? OP_WR : OP_PIX;
      slot = 4'($urandom_range(0, 15));
      ref_color = palette_model[$urandom_range(0, npcm_pkg::PALETTE_SIZE - 1)];
      pick = $urandom_range(0, 99);
      if (op == OP_WR) begin
        if (pick < 25) begin
          // Duplicate colors make ties between slots.
          {r, g, b} = ref_color;
        end else if (pick < 45) begin
          r = extreme_comp();
          g = extreme_comp();
          b = extreme_comp();
        end else begin
          r = 8'($urandom_range(0, 255));
          g = 8'($urandom_range(0, 255));
          b = 8'($urandom_range(0, 255));
        end
      end else begin
        if (pick < 20) begin
          {r, g, b} = ref_color;
        end else if (pick < 55) begin
          r = jitter(ref_color[23:16]);
          g = jitter(ref_color[15:8]);
          b = jitter(ref_color[7:0]);
        end else if (pick < 70) begin
          r = extreme_comp();
          g = extreme_comp();
          b = extreme_comp();
        end else begin
          r = 8'($urandom_range(0, 255));
          g = 8'($urandom_range(0, 255));
          b = 8'($urandom_range(0, 255));
        end
      end
      send_item(op, r, g, b, slot, 1'b0, 4'd0, send_gap());
    end
    in_tvalid <= 1'b0;

    // Drain the row, then give it time to show any stray result.
    while (color_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d palette writes and %0d pixels (%0d on duplicated entries).",
             write_count, pixel_count, tie_pixels);
    $display("Checked %0d results with random gaps and receiver stalls, %0d mismatches.",
             result_count, error_count);
    if (error_count == 0) begin
      $display("nearest_palette_color_match_core_tb: clean");
    end else begin
      $display("nearest_palette_color_match_core_tb: errors");
    end
    $finish;
  end

endmodule
